/* design/tlar_pkg.sv */
`timescale 1ns / 1ps
package tlar_pkg;

  localparam int MAX_RANK  = 4;
  localparam int OUT_DEPTH = 4096;
  localparam int ADDR_W    = $clog2(OUT_DEPTH);
  localparam int DIM_W     = 16;
  localparam int RANK_W    = 3;
  localparam int MASK_W    = MAX_RANK;
  localparam int DSEL_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

  // saturating kept-extent product, one above the store depth is enough
  localparam int SAT_W     = ADDR_W + 1;
  localparam logic [SAT_W-1:0] SAT_MAX = SAT_W'(OUT_DEPTH + 1);

  // configuration port
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RANK = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIM0 = 3'd2;

  // stride chain settles dimension by dimension after a write
  localparam int SETTLE_W  = $clog2(MAX_RANK + 1);
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(MAX_RANK);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((1 + ADDR_W + 7) / 8) * 8;

  typedef struct packed {
    logic [RANK_W-1:0]                 rank;
    logic [MASK_W-1:0]                 mask;
    logic [MAX_RANK-1:0][DIM_W-1:0]    ext;
    logic [MAX_RANK-1:0][ADDR_W-1:0]   stride;
    logic                              ovf;
    logic                              busy;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              finished;
    logic              last;
  } op_t;

  typedef struct packed {
    logic              value;
    logic [ADDR_W-1:0] index;
    logic              last;
    logic              ovf;
  } res_t;

endpackage

/* design/tlar_cfg.sv */
`timescale 1ns / 1ps
module tlar_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tlar_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [tlar_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [tlar_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  output tlar_pkg::cfg_t                  cfg
);

  logic [tlar_pkg::RANK_W-1:0]   rank_r;
  logic [tlar_pkg::MASK_W-1:0]   mask_r;
  logic [tlar_pkg::DIM_W-1:0]    dim_r [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::ADDR_W-1:0]   stride_r [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::ADDR_W-1:0]   stride_nxt [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::SAT_W-1:0]    sat_r [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::SAT_W-1:0]    sat_nxt [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::SETTLE_W-1:0] settle_r;
  logic [tlar_pkg::RANK_W-1:0]   rank_eff;
  logic [tlar_pkg::DIM_W-1:0]    ext [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::DIM_W-1:0]    keep_ext [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::REG_IDX_W-1:0] idx;
  logic [tlar_pkg::REG_IDX_W-1:0] dsel;
  logic                          wr;

  assign cfg_pready = 1'b1;
  assign idx  = cfg_paddr[tlar_pkg::CFG_AW-1:2];
  assign dsel = idx - tlar_pkg::REG_DIM0;
  assign wr   = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= tlar_pkg::RANK_W'(1);
      mask_r <= '1;
      for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
        dim_r[d] <= tlar_pkg::DIM_W'(1);
      end
    end else if (wr) begin
      if (idx == tlar_pkg::REG_RANK) begin
        rank_r <= cfg_pwdata[tlar_pkg::RANK_W-1:0];
      end else if (idx == tlar_pkg::REG_MASK) begin
        mask_r <= cfg_pwdata[tlar_pkg::MASK_W-1:0];
      end else if (idx >= tlar_pkg::REG_DIM0 &&
                   dsel < tlar_pkg::REG_IDX_W'(tlar_pkg::MAX_RANK)) begin
        dim_r[dsel[tlar_pkg::DSEL_W-1:0]] <= cfg_pwdata[tlar_pkg::DIM_W-1:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx == tlar_pkg::REG_RANK) begin
      cfg_prdata = tlar_pkg::CFG_DW'(rank_r);
    end else if (idx == tlar_pkg::REG_MASK) begin
      cfg_prdata = tlar_pkg::CFG_DW'(mask_r);
    end else if (idx >= tlar_pkg::REG_DIM0 &&
                 dsel < tlar_pkg::REG_IDX_W'(tlar_pkg::MAX_RANK)) begin
      cfg_prdata = tlar_pkg::CFG_DW'(dim_r[dsel[tlar_pkg::DSEL_W-1:0]]);
    end
  end

  // rank 0 acts as 1, above the maximum acts as the maximum; extent 0 acts as 1
  always_comb begin
    if (rank_r == '0) begin
      rank_eff = tlar_pkg::RANK_W'(1);
    end else if (rank_r > tlar_pkg::RANK_W'(tlar_pkg::MAX_RANK)) begin
      rank_eff = tlar_pkg::RANK_W'(tlar_pkg::MAX_RANK);
    end else begin
      rank_eff = rank_r;
    end
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      ext[d] = (dim_r[d] == '0) ? tlar_pkg::DIM_W'(1) : dim_r[d];
      keep_ext[d] = (tlar_pkg::RANK_W'(d) < rank_eff && !mask_r[d]) ?
                    ext[d] : tlar_pkg::DIM_W'(1);
    end
  end

  // kept strides and saturated kept product, one stride and one product multiply per stage
  always_comb begin
    logic [2*tlar_pkg::ADDR_W-1:0]            sp;
    logic [tlar_pkg::SAT_W+tlar_pkg::DIM_W-1:0] pp;
    sp = '0;
    pp = '0;
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      if (d == tlar_pkg::MAX_RANK - 1) begin
        stride_nxt[d] = tlar_pkg::ADDR_W'(1);
        pp = (tlar_pkg::SAT_W + tlar_pkg::DIM_W)'(keep_ext[d]);
      end else begin
        sp = (2 * tlar_pkg::ADDR_W)'(stride_r[d+1]) *
             (2 * tlar_pkg::ADDR_W)'(keep_ext[d+1][tlar_pkg::ADDR_W-1:0]);
        stride_nxt[d] = sp[tlar_pkg::ADDR_W-1:0];
        pp = (tlar_pkg::SAT_W + tlar_pkg::DIM_W)'(sat_r[d+1]) *
             (tlar_pkg::SAT_W + tlar_pkg::DIM_W)'(keep_ext[d]);
      end
      sat_nxt[d] = (pp > (tlar_pkg::SAT_W + tlar_pkg::DIM_W)'(tlar_pkg::SAT_MAX)) ?
                   tlar_pkg::SAT_MAX : pp[tlar_pkg::SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      stride_r[d] <= stride_nxt[d];
      sat_r[d]    <= sat_nxt[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= tlar_pkg::SETTLE_CYCLES;
    end else if (wr) begin
      settle_r <= tlar_pkg::SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - tlar_pkg::SETTLE_W'(1);
    end
  end

  always_comb begin
    cfg.rank = rank_eff;
    cfg.mask = mask_r;
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      cfg.ext[d]    = ext[d];
      cfg.stride[d] = stride_r[d];
    end
    cfg.ovf  = sat_r[0] > tlar_pkg::SAT_W'(tlar_pkg::OUT_DEPTH);
    cfg.busy = settle_r != '0;
  end

endmodule

/* design/tlar_coord.sv */
`timescale 1ns / 1ps
module tlar_coord (
  input  logic           clk,
  input  logic           rst_n,
  input  tlar_pkg::cfg_t cfg,
  input  logic           advance,
  output tlar_pkg::op_t  op
);

  logic [tlar_pkg::DIM_W-1:0]  cnt_r   [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::DIM_W-1:0]  cnt_nxt [tlar_pkg::MAX_RANK];
  logic [tlar_pkg::MAX_RANK-1:0] at_max;
  logic [tlar_pkg::MAX_RANK-1:0] in_rank;
  logic [tlar_pkg::ADDR_W-1:0] term [tlar_pkg::MAX_RANK];

  // a coordinate at or past extent-1 counts as at its maximum
  always_comb begin
    logic [2*tlar_pkg::ADDR_W-1:0] prod;
    prod = '0;
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      in_rank[d] = tlar_pkg::RANK_W'(d) < cfg.rank;
      at_max[d]  = cnt_r[d] >= cfg.ext[d] - tlar_pkg::DIM_W'(1);
      prod = (2 * tlar_pkg::ADDR_W)'(cnt_r[d][tlar_pkg::ADDR_W-1:0]) *
             (2 * tlar_pkg::ADDR_W)'(cfg.stride[d]);
      term[d] = (in_rank[d] && !cfg.mask[d]) ? prod[tlar_pkg::ADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    op.addr     = '0;
    op.first    = 1'b1;
    op.finished = 1'b1;
    op.last     = 1'b1;
    for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
      op.addr = op.addr + term[d];
      if (in_rank[d]) begin
        if (!at_max[d]) begin
          op.last = 1'b0;
        end
        if (cfg.mask[d]) begin
          if (cnt_r[d] != '0) begin
            op.first = 1'b0;
          end
          if (!at_max[d]) begin
            op.finished = 1'b0;
          end
        end
      end
    end
  end

  // row-major step, innermost fastest, wraps after the final element
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = tlar_pkg::MAX_RANK - 1; d >= 0; d--) begin
      cnt_nxt[d] = cnt_r[d];
      if (in_rank[d]) begin
        if (carry) begin
          cnt_nxt[d] = at_max[d] ? '0 : cnt_r[d] + tlar_pkg::DIM_W'(1);
        end
        carry = carry & at_max[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
        cnt_r[d] <= '0;
      end
    end else if (advance) begin
      for (int d = 0; d < tlar_pkg::MAX_RANK; d++) begin
        cnt_r[d] <= cnt_nxt[d];
      end
    end
  end

endmodule

/* design/tlar_store.sv */
`timescale 1ns / 1ps
module tlar_store (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  tlar_pkg::op_t  op,
  input  logic           elem,
  input  logic           ovf,
  input  logic           take,
  output logic           s1_valid,
  output logic           s1_finished,
  output tlar_pkg::res_t res
);

  logic                         mem [tlar_pkg::OUT_DEPTH];
  logic                         rd_r;
  logic                         valid_r;
  tlar_pkg::op_t                op_r;
  logic                         elem_r;
  logic                         ovf_r;
  logic                         fwd_r;
  logic                         fwd_val_r;
  logic                         acc;
  logic                         leave;

  assign leave = valid_r & take;

  // forward the entry being written at the same edge as the read
  assign acc = op_r.first ? elem_r : ((fwd_r ? fwd_val_r : rd_r) & elem_r);

  always_ff @(posedge clk) begin
    if (load) begin
      rd_r <= mem[op.addr];
    end
    if (leave) begin
      mem[op_r.addr] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r      <= op;
      elem_r    <= elem;
      ovf_r     <= ovf;
      fwd_r     <= leave && (op_r.addr == op.addr);
      fwd_val_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (leave) begin
      valid_r <= 1'b0;
    end
  end

  assign s1_valid    = valid_r;
  assign s1_finished = op_r.finished;
  assign res.value   = acc;
  assign res.index   = op_r.addr;
  assign res.last    = op_r.last;
  assign res.ovf     = ovf_r;

endmodule

/* design/tensor_logical_and_axis_reduce.sv */
`timescale 1ns / 1ps
// Logical-AND reduction over the axes picked by reduce_mask of a boolean tensor
// streamed one element per transaction in row-major order. One element is
// taken every clock unless a finished group waits for the output register or
// the strides settle; the accumulator store is read in the cycle an element is
// accepted and written as it leaves the store stage, with a bypass for
// back-to-back hits on the same entry, and a finished group's result moves from
// the store stage into the output register. Each configuration write holds
// in_tready low while the kept-stride multiply chain settles dimension by
// dimension. The store is never cleared: a group's first element sets its entry.
module tensor_logical_and_axis_reduce (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tlar_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] element
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tlar_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [0] out_value, [12:1] out_index
  output logic                               out_tlast,  // last_output
  output logic                               out_tuser,  // [0] store_overflow
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [tlar_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [tlar_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [tlar_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  tlar_pkg::cfg_t cfg;
  tlar_pkg::op_t  op;
  tlar_pkg::res_t res;
  tlar_pkg::res_t out_r;
  logic           out_valid_r;
  logic           s1_valid;
  logic           s1_finished;
  logic           take;
  logic           accept;

  tlar_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  tlar_coord u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (accept),
    .op      (op)
  );

  tlar_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .op          (op),
    .elem        (in_tdata[0]),
    .ovf         (cfg.ovf),
    .take        (take),
    .s1_valid    (s1_valid),
    .s1_finished (s1_finished),
    .res         (res)
  );

  // an unfinished group moves on without needing the output slot
  assign take      = s1_valid & (~s1_finished | ~out_valid_r | out_tready);
  assign in_tready = ~cfg.busy & (~s1_valid | take);
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && s1_finished) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_finished) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tlar_pkg::OUT_TDATA_W'({out_r.index, out_r.value});
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.ovf;

endmodule

/* design/tlar_chk.sv */
`timescale 1ns / 1ps
module tlar_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlar_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic                             cfg_pready
);

  logic cfg_wr;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // stalled result transaction keeps its valid and data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // input held off while the stride chain settles
  a_cfg_hold1: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_tready)
    else $error("input taken right after a register write");

  a_cfg_hold4: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |-> ##4 !in_tready)
    else $error("input taken before strides settled");

endmodule

bind tensor_logical_and_axis_reduce tlar_chk u_tlar_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready)
);

/* tb/sv/and_reduce_checker.sv */
`timescale 1ns / 1ps
module and_reduce_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tlar_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] element
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tlar_pkg::OUT_TDATA_W-1:0] out_tdata,  // [0] out_value, [12:1] out_index
  input  logic                             out_tlast,  // last_output
  input  logic                             out_tuser,  // [0] store_overflow
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tlar_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [tlar_pkg::CFG_DW-1:0]      cfg_pwdata,
  input  logic [tlar_pkg::CFG_DW-1:0]      cfg_prdata,
  input  logic                             cfg_pready,
  output int                               mismatches,
  output int                               outstanding
);
  import tlar_pkg::*;

  logic [RANK_W-1:0] shape_rank;
  logic [MASK_W-1:0] shape_mask;
  logic [DIM_W-1:0]  shape_dim [MAX_RANK];
  logic [DIM_W-1:0]  coord [MAX_RANK];
  bit                group_and [OUT_DEPTH];
  res_t              expected_groups [$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int extent_of(input int d);
    return (shape_dim[d] == '0) ? 1 : int'(shape_dim[d]);
  endfunction

  function automatic logic [CFG_DW-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    if (idx == REG_RANK) return CFG_DW'(shape_rank);
    if (idx == REG_MASK) return CFG_DW'(shape_mask);
    if (int'(idx) >= int'(REG_DIM0) + MAX_RANK) return '0;
    return CFG_DW'(shape_dim[int'(idx) - int'(REG_DIM0)]);
  endfunction

  // folds one element into its group and advances the coordinates
  function automatic bit fold_element(input bit elem, output res_t res);
    int               r;
    longint unsigned  kidx;
    longint unsigned  kprod;
    bit               first;
    bit               finished;
    bit               last;
    bit               carry;
    bit               acc;
    logic [ADDR_W-1:0] addr;
    r = (shape_rank == '0) ? 1 : (int'(shape_rank) > MAX_RANK) ? MAX_RANK : int'(shape_rank);
    kidx = 0;
    kprod = 1;
    first = 1'b1;
    finished = 1'b1;
    last = 1'b1;
    for (int d = 0; d < r; d++) begin
      if (int'(coord[d]) + 1 < extent_of(d)) last = 1'b0;
      if (shape_mask[d]) begin
        if (coord[d] != '0) first = 1'b0;
        if (int'(coord[d]) + 1 < extent_of(d)) finished = 1'b0;
      end else begin
        kidx = kidx * longint'(extent_of(d)) + longint'(coord[d]);
        kprod = kprod * longint'(extent_of(d));
      end
    end
    addr = kidx[ADDR_W-1:0];
    acc = first ? elem : (group_and[addr] & elem);
    group_and[addr] = acc;
    res.value = acc;
    res.index = kidx[ADDR_W-1:0];
    res.last = last;
    res.ovf = (kprod > longint'(OUT_DEPTH));
    // innermost first; a coordinate at or past its maximum wraps and carries
    carry = 1'b1;
    for (int d = r - 1; d >= 0; d--) begin
      if (carry) begin
        if (int'(coord[d]) + 1 >= extent_of(d)) begin
          coord[d] = '0;
        end else begin
          coord[d] = coord[d] + 1'b1;
          carry = 1'b0;
        end
      end
    end
    return finished;
  endfunction

  always @(posedge clk) begin : watch
    res_t                 got;
    res_t                 want;
    res_t                 fresh;
    logic [REG_IDX_W-1:0] idx;
    idx = cfg_paddr[CFG_AW-1:2];
    if (!rst_n) begin
      shape_rank = RANK_W'(1);
      shape_mask = '1;
      for (int d = 0; d < MAX_RANK; d++) begin
        shape_dim[d] = DIM_W'(1);
        coord[d] = '0;
      end
      expected_groups.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[0];
        got.index = out_tdata[ADDR_W:1];
        got.last = out_tlast;
        got.ovf = out_tuser;
        if (expected_groups.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, got %h", $time, got);
        end else begin
          want = expected_groups.pop_front();
          if (got !== want) begin
            mismatches++;
            if (got.value !== want.value)
              $display("%0t: out_value expected %0d got %0d", $time, want.value, got.value);
            if (got.index !== want.index)
              $display("%0t: out_index expected %0d got %0d", $time, want.index, got.index);
            if (got.last !== want.last)
              $display("%0t: last_output expected %0d got %0d", $time, want.last, got.last);
            if (got.ovf !== want.ovf)
              $display("%0t: store_overflow expected %0d got %0d", $time, want.ovf, got.ovf);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (fold_element(in_tdata[0], fresh)) expected_groups = {expected_groups, fresh};
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (idx == REG_RANK) shape_rank = cfg_pwdata[RANK_W-1:0];
          else if (idx == REG_MASK) shape_mask = cfg_pwdata[MASK_W-1:0];
          else if (int'(idx) >= int'(REG_DIM0) && int'(idx) < int'(REG_DIM0) + MAX_RANK)
            shape_dim[int'(idx) - int'(REG_DIM0)] = cfg_pwdata[DIM_W-1:0];
        end else if (cfg_prdata !== reg_value(idx)) begin
          mismatches++;
          $display("%0t: register %0d read expected %h got %h", $time, idx,
                   reg_value(idx), cfg_prdata);
        end
      end
    end
    outstanding = expected_groups.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tlar_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [0] element
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] out_value, [12:1] out_index
  logic                   out_tlast;  // last_output
  logic                   out_tuser;  // [0] store_overflow
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;
  int                     mismatches;
  int                     outstanding;

  logic [RANK_W-1:0] cur_rank;
  logic [MASK_W-1:0] cur_mask;
  logic [DIM_W-1:0]  cur_dim [MAX_RANK];
  int                zero_pct;
  bit                no_gaps;
  int                elements_sent;

  tensor_logical_and_axis_reduce u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  and_reduce_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tensor_logical_and_axis_reduce test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // elements in one whole tensor of the pending shape
  function automatic int shape_elems();
    int r;
    int n;
    r = (cur_rank == '0) ? 1 : (int'(cur_rank) > MAX_RANK) ? MAX_RANK : int'(cur_rank);
    n = 1;
    for (int d = 0; d < r; d++) n = n * ((cur_dim[d] == '0) ? 1 : int'(cur_dim[d]));
    return n;
  endfunction

  // random junk above the register width now and then
  function automatic logic [CFG_DW-1:0] with_noise(input logic [CFG_DW-1:0] v, input int w);
    logic [CFG_DW-1:0] keep;
    keep = (CFG_DW'(1) << w) - CFG_DW'(1);
    if ($urandom_range(0, 3) == 0) return (CFG_DW'($urandom) & ~keep) | v;
    return v;
  endfunction

  task automatic cfg_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= wr;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic apply_shape();
    cfg_access(1'b1, REG_RANK, with_noise(CFG_DW'(cur_rank), RANK_W));
    cfg_access(1'b1, REG_MASK, with_noise(CFG_DW'(cur_mask), MASK_W));
    for (int d = 0; d < MAX_RANK; d++)
      cfg_access(1'b1, REG_DIM0 + REG_IDX_W'(d), with_noise(CFG_DW'(cur_dim[d]), DIM_W));
    cfg_access(1'b0, REG_IDX_W'($urandom_range(0, 5)), '0);
  endtask

  task automatic set_cur(input logic [RANK_W-1:0] rk, input logic [MASK_W-1:0] mk,
                         input int d0, input int d1, input int d2, input int d3);
    cur_rank = rk;
    cur_mask = mk;
    cur_dim[0] = DIM_W'(d0);
    cur_dim[1] = DIM_W'(d1);
    cur_dim[2] = DIM_W'(d2);
    cur_dim[3] = DIM_W'(d3);
    apply_shape();
  endtask

  // entered and left at a falling edge
  task automatic send_element(input bit elem);
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(elem);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic send_pattern(input logic [31:0] pat, input int n);
    for (int i = 0; i < n; i++) send_element(pat[i]);
  endtask

  task automatic send_run(input int n, input int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_until_drained();
      send_element($urandom_range(0, 99) >= zero_pct);
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    hold_until_drained();
    repeat (8) @(negedge clk);
  endtask

  // all extents one and nothing reduced: one element puts every counter back to zero
  task automatic realign();
    wait_idle();
    set_cur(3'd4, 4'b0000, 1, 1, 1, 1);
    send_element(1'($urandom_range(0, 1)));
  endtask

  initial begin : result_sink
    int stall_left;
    int mode_left;
    int r;
    bit steady;
    stall_left = 0;
    mode_left = 0;
    steady = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 80) ? $urandom_range(0, 2) :
                     (r < 95) ? $urandom_range(3, 9) : $urandom_range(19, 39);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int kind;
    int n;
    int hold_at;
    int r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_rank = RANK_W'(1);
    cur_mask = '1;
    for (int d = 0; d < MAX_RANK; d++) cur_dim[d] = DIM_W'(1);
    zero_pct = 20;
    no_gaps = 1'b0;
    elements_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset shape: every element is a group of its own
    send_pattern(32'b01, 2);
    wait_idle();
    // inner axis reduced, sender held until the first group is out
    set_cur(3'd2, 4'b0010, 2, 3, 1, 1);
    send_pattern(32'b111, 3);
    hold_until_drained();
    send_pattern(32'b101, 3);
    wait_idle();
    // rank zero behaves as rank one
    set_cur(3'd0, 4'b0001, 3, 1, 1, 1);
    send_pattern(32'b111, 3);
    wait_idle();
    // rank above the maximum, zero extent on dimension one
    set_cur(3'd7, 4'b0100, 1, 0, 2, 1);
    send_pattern(32'b10, 2);
    wait_idle();
    // mask bits past rank only, so elements pass straight through
    set_cur(3'd1, 4'b1110, 3, 1, 1, 1);
    send_pattern(32'b101, 3);
    wait_idle();
    // kept product beyond the store, left mid-tensor, counters past extent after
    set_cur(3'd2, 4'b0000, 65, 64, 1, 1);
    send_pattern(32'b110, 3);
    realign();
    wait_idle();
    // whole tensor to a single value
    set_cur(3'd4, 4'b1111, 2, 1, 1, 2);
    send_pattern(32'b1111, 4);

    while (elements_sent < 900) begin
      kind = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 3);
      zero_pct = (r == 0) ? 0 : (r == 1) ? 3 : (r == 2) ? 15 : 50;
      wait_idle();
      if (kind < 8) begin
        do begin
          r = $urandom_range(0, 15);
          cur_rank = (r == 0) ? RANK_W'(0) :
                     (r == 1) ? RANK_W'($urandom_range(5, 7)) : RANK_W'($urandom_range(1, 4));
          cur_mask = MASK_W'($urandom_range(0, 15));
          for (int d = 0; d < MAX_RANK; d++) begin
            r = $urandom_range(0, 9);
            cur_dim[d] = (r == 0) ? DIM_W'(0) :
                         (r < 7) ? DIM_W'($urandom_range(1, 4)) : DIM_W'($urandom_range(5, 12));
          end
        end while (shape_elems() > 96);
        apply_shape();
        n = shape_elems();
        if (n <= 16) n = n * $urandom_range(1, 3);
        hold_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1;
        send_run(n, hold_at);
      end else begin
        // broken tensor: huge or random extents, abandoned part way
        cur_rank = RANK_W'($urandom_range(0, 7));
        cur_mask = MASK_W'($urandom_range(0, 15));
        for (int d = 0; d < MAX_RANK; d++) begin
          r = $urandom_range(0, 3);
          cur_dim[d] = (r == 0) ? DIM_W'(65535) :
                       (r == 1) ? DIM_W'($urandom_range(0, 65535)) : DIM_W'($urandom_range(1, 8));
        end
        apply_shape();
        send_run($urandom_range(1, 30), -1);
        realign();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("tensor_logical_and_axis_reduce test passed");
    end else begin
      $display("tensor_logical_and_axis_reduce test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/tlar_pkg.sv
design/tlar_cfg.sv
design/tlar_coord.sv
design/tlar_store.sv
design/tensor_logical_and_axis_reduce.sv
design/tlar_chk.sv
tb/sv/and_reduce_checker.sv
tb/sv/tb.sv
